FILE: sv/arpt_pkg.sv
// shared types and constants of the address range policy table
`timescale 1ns / 1ps

package arpt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ADDR_W     = 48;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    // policies, larger is stricter
    localparam logic [1:0] POL_NONE     = 2'd0;
    localparam logic [1:0] POL_TIMING   = 2'd1;
    localparam logic [1:0] POL_LEGACY   = 2'd2;
    localparam logic [1:0] POL_CAPACITY = 2'd3;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_MISS    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [1:0]        policy;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

endpackage

FILE: sv/arpt_store.sv
// range table storage: one write port, one registered read port
`timescale 1ns / 1ps

module arpt_store (
    input  logic                        i_clk,
    input  arpt_pkg::t_wr_req           i_wr,
    input  logic [arpt_pkg::IDX_W-1:0]  i_rd_addr,
    output arpt_pkg::t_entry            o_rd_data
);

    arpt_pkg::t_entry r_mem [arpt_pkg::MAX_RANGES];
    arpt_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/address_range_policy_table_core.sv
// top level of the address range policy table with its command sequencer
// Usage:
//   Input channel i_valid/o_ready carries one command per transfer: add,
//   remove, clear or lookup, with range bounds, policy and lookup address.
//   Output channel o_valid/i_ready returns one result per command: status,
//   strictest covering policy and the table summary flags after the command.
// Sequencing:
//   add and clear go straight from the transfer to the result stage.
//   lookup walks the stored ranges upward; remove walks them downward from
//   the newest and, when the newest match is entry h, moves every entry
//   above the match down by one. Both walk the table through the single
//   read port of the storage, one entry per cycle.
//   One command is processed at a time; o_ready is high only when idle.
// Reset:
//   the table is empty after reset; no clearing pass is needed since only
//   entries below the fill count are ever read.
// Stall:
//   a result waits in the output register; the next command is accepted and
//   processed meanwhile, and its result is held until the register frees up.
`timescale 1ns / 1ps

module address_range_policy_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_command,
    input  logic [arpt_pkg::ADDR_W-1:0]  i_range_begin,
    input  logic [arpt_pkg::ADDR_W-1:0]  i_range_end,
    input  logic [1:0]                   i_range_policy,
    input  logic [arpt_pkg::ADDR_W-1:0]  i_lookup_address,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [1:0]                   o_found_policy,
    output logic                         o_any_range,
    output logic                         o_any_strict,
    output logic                         o_any_capacity
);

    localparam int IDX_W = arpt_pkg::IDX_W;
    localparam int CNT_W = arpt_pkg::CNT_W;
    localparam int ADDR_W = arpt_pkg::ADDR_W;

    // control state
    arpt_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cnt_strict, n_cnt_strict;
    logic [CNT_W-1:0]   r_cnt_cap, n_cnt_cap;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic               r_o_valid, n_o_valid;

    // payload state
    arpt_pkg::t_cmd     r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_lo, n_lo;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [IDX_W-1:0]   r_rd_tag, n_rd_tag;
    logic [1:0]         r_found, n_found;
    arpt_pkg::t_status  r_status, n_status;
    logic [1:0]         r_rm_pol, n_rm_pol;
    logic [1:0]         r_o_status, n_o_status;
    logic [1:0]         r_o_found, n_o_found;
    logic               r_o_any_range, n_o_any_range;
    logic               r_o_any_strict, n_o_any_strict;
    logic               r_o_any_cap, n_o_any_cap;

    // storage interface
    arpt_pkg::t_wr_req  wr_req;
    logic [IDX_W-1:0]   rd_addr;
    arpt_pkg::t_entry   rd_data;
    logic [CNT_W-1:0]   idx_dec;

    arpt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign idx_dec = r_idx - CNT_W'(1);

    // sequencer: next state, table updates and result capture
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_cnt_strict   = r_cnt_strict;
        n_cnt_cap      = r_cnt_cap;
        n_idx          = r_idx;
        n_rd_vld       = 1'b0;
        n_o_valid      = r_o_valid;
        n_cmd          = r_cmd;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_addr         = r_addr;
        n_rd_tag       = r_idx[IDX_W-1:0];
        n_found        = r_found;
        n_status       = r_status;
        n_rm_pol       = r_rm_pol;
        n_o_status     = r_o_status;
        n_o_found      = r_o_found;
        n_o_any_range  = r_o_any_range;
        n_o_any_strict = r_o_any_strict;
        n_o_any_cap    = r_o_any_cap;
        wr_req         = '0;
        rd_addr        = r_idx[IDX_W-1:0];

        // output register drains on transfer
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            arpt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = arpt_pkg::t_cmd'(i_command);
                    n_lo     = i_range_begin;
                    n_hi     = i_range_end;
                    n_addr   = i_lookup_address;
                    n_found  = arpt_pkg::POL_NONE;
                    n_status = arpt_pkg::STATUS_OK;
                    case (arpt_pkg::t_cmd'(i_command))
                        arpt_pkg::CMD_ADD: begin
                            n_state = arpt_pkg::S_DONE;
                            if (i_range_begin >= i_range_end ||
                                i_range_policy == arpt_pkg::POL_NONE) begin
                                n_status = arpt_pkg::STATUS_INVALID;
                            end else if (r_count >= CNT_W'(arpt_pkg::MAX_RANGES)) begin
                                n_status = arpt_pkg::STATUS_FULL;
                            end else begin
                                wr_req.en          = 1'b1;
                                wr_req.addr        = r_count[IDX_W-1:0];
                                wr_req.data.lo     = i_range_begin;
                                wr_req.data.hi     = i_range_end;
                                wr_req.data.policy = i_range_policy;
                                n_count            = r_count + CNT_W'(1);
                                if (i_range_policy inside {arpt_pkg::POL_LEGACY,
                                                           arpt_pkg::POL_CAPACITY}) begin
                                    n_cnt_strict = r_cnt_strict + CNT_W'(1);
                                end
                                if (i_range_policy == arpt_pkg::POL_CAPACITY) begin
                                    n_cnt_cap = r_cnt_cap + CNT_W'(1);
                                end
                            end
                        end
                        arpt_pkg::CMD_REMOVE: begin
                            n_idx   = r_count;
                            n_state = arpt_pkg::S_SCAN;
                        end
                        arpt_pkg::CMD_CLEAR: begin
                            n_count      = '0;
                            n_cnt_strict = '0;
                            n_cnt_cap    = '0;
                            n_state      = arpt_pkg::S_DONE;
                        end
                        arpt_pkg::CMD_LOOKUP: begin
                            n_idx   = '0;
                            n_state = arpt_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = arpt_pkg::S_DONE;
                        end
                    endcase
                end
            end

            arpt_pkg::S_SCAN: begin
                if (r_cmd == arpt_pkg::CMD_LOOKUP) begin
                    // upward walk, keep strictest covering policy
                    if (r_rd_vld && r_addr >= rd_data.lo && r_addr < rd_data.hi &&
                        rd_data.policy > r_found) begin
                        n_found = rd_data.policy;
                    end
                    if (r_idx == r_count) begin
                        n_state = arpt_pkg::S_DONE;
                    end else begin
                        rd_addr  = r_idx[IDX_W-1:0];
                        n_rd_vld = 1'b1;
                        n_rd_tag = r_idx[IDX_W-1:0];
                        n_idx    = r_idx + CNT_W'(1);
                    end
                end else begin
                    // downward walk, newest exact match wins
                    if (r_rd_vld && rd_data.lo == r_lo && rd_data.hi == r_hi) begin
                        n_rm_pol = rd_data.policy;
                        n_idx    = CNT_W'(r_rd_tag) + CNT_W'(1);
                        n_state  = arpt_pkg::S_SHIFT;
                    end else if (r_idx == '0) begin
                        n_status = arpt_pkg::STATUS_MISS;
                        n_state  = arpt_pkg::S_DONE;
                    end else begin
                        rd_addr  = idx_dec[IDX_W-1:0];
                        n_rd_vld = 1'b1;
                        n_rd_tag = idx_dec[IDX_W-1:0];
                        n_idx    = idx_dec;
                    end
                end
            end

            arpt_pkg::S_SHIFT: begin
                // move each later entry down by one
                if (r_rd_vld) begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = r_rd_tag - IDX_W'(1);
                    wr_req.data = rd_data;
                end
                if (r_idx == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_rm_pol inside {arpt_pkg::POL_LEGACY, arpt_pkg::POL_CAPACITY}) begin
                        n_cnt_strict = r_cnt_strict - CNT_W'(1);
                    end
                    if (r_rm_pol == arpt_pkg::POL_CAPACITY) begin
                        n_cnt_cap = r_cnt_cap - CNT_W'(1);
                    end
                    n_state = arpt_pkg::S_DONE;
                end else begin
                    rd_addr  = r_idx[IDX_W-1:0];
                    n_rd_vld = 1'b1;
                    n_rd_tag = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + CNT_W'(1);
                end
            end

            arpt_pkg::S_DONE: begin
                // hand result to the output register once it is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid      = 1'b1;
                    n_o_status     = r_status;
                    n_o_found      = r_found;
                    n_o_any_range  = (r_count != '0);
                    n_o_any_strict = (r_cnt_strict != '0);
                    n_o_any_cap    = (r_cnt_cap != '0);
                    n_state        = arpt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = arpt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= arpt_pkg::S_IDLE;
            r_count      <= '0;
            r_cnt_strict <= '0;
            r_cnt_cap    <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_cnt_strict <= n_cnt_strict;
            r_cnt_cap    <= n_cnt_cap;
            r_idx        <= n_idx;
            r_rd_vld     <= n_rd_vld;
            r_o_valid    <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_lo           <= n_lo;
        r_hi           <= n_hi;
        r_addr         <= n_addr;
        r_rd_tag       <= n_rd_tag;
        r_found        <= n_found;
        r_status       <= n_status;
        r_rm_pol       <= n_rm_pol;
        r_o_status     <= n_o_status;
        r_o_found      <= n_o_found;
        r_o_any_range  <= n_o_any_range;
        r_o_any_strict <= n_o_any_strict;
        r_o_any_cap    <= n_o_any_cap;
    end

    // ports
    assign o_ready        = (r_state == arpt_pkg::S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_found_policy = r_o_found;
    assign o_any_range    = r_o_any_range;
    assign o_any_strict   = r_o_any_strict;
    assign o_any_capacity = r_o_any_cap;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(arpt_pkg::MAX_RANGES))
        else $error("range count beyond table depth");

    a_policy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_cap <= r_cnt_strict && r_cnt_strict <= r_count)
        else $error("policy counters inconsistent with range count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_command == arpt_pkg::CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left ranges in table");

    a_shift_on_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == arpt_pkg::S_SHIFT) |-> (r_cmd == arpt_pkg::CMD_REMOVE && r_count != '0))
        else $error("compaction outside a remove");

    a_capacity_is_strict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_any_capacity) |-> (o_any_strict && o_any_range))
        else $error("summary flags inconsistent");

endmodule
